>>> rtl/utu8_pkg.sv
// ----------------------------------------------------------------------------
// utu8_pkg
// Shared types, constants and encode helpers for the UTF-16/UTF-32 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package utu8_pkg;

	localparam int CP_W = 21;

	typedef logic [CP_W-1:0] cp_t;

	// input_mode register values
	localparam logic MODE_UTF16 = 1'b0;
	localparam logic MODE_UTF32 = 1'b1;

	// surrogate prefixes (top six bits of a 16-bit unit)
	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

	localparam cp_t        SUPP_BASE = 21'h010000;
	localparam logic [31:0] CP_MAX   = 32'h0010FFFF;

	localparam cp_t LIMIT_1B = 21'h000080;
	localparam cp_t LIMIT_2B = 21'h000800;
	localparam cp_t LIMIT_3B = 21'h010000;

	// sequence length minus one
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} seq_len_t;

	// one queued job: up to two code points produced by one item
	typedef struct packed {
		logic first_v;
		cp_t  first_cp;
		logic second_v;
		cp_t  second_cp;
	} job_t;

	function automatic seq_len_t utf8_len(input cp_t cp);
		seq_len_t l;
		if (cp < LIMIT_1B)      l = LEN_1;
		else if (cp < LIMIT_2B) l = LEN_2;
		else if (cp < LIMIT_3B) l = LEN_3;
		else                    l = LEN_4;
		return l;
	endfunction

	// byte idx of the UTF-8 sequence for cp
	function automatic logic [7:0] utf8_byte_at(input cp_t cp, input seq_len_t len,
		input logic [1:0] idx);
		logic [7:0] b;
		b = {2'b10, cp[5:0]};
		case (len)
			LEN_1: b = {1'b0, cp[6:0]};
			LEN_2: begin
				if (idx == 2'd0) b = {3'b110, cp[10:6]};
			end
			LEN_3: begin
				case (idx)
					2'd0: b = {4'b1110, cp[15:12]};
					2'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LEN_4: begin
				case (idx)
					2'd0: b = {5'b11110, cp[20:18]};
					2'd1: b = {2'b10, cp[17:12]};
					2'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {2'b10, cp[5:0]};
		endcase
		return b;
	endfunction

endpackage

>>> rtl/utu8_front.sv
// ----------------------------------------------------------------------------
// utu8_front
// Accepts code units, tracks the held high surrogate and turns each item into
// a job of up to two code points for the back end.
// ----------------------------------------------------------------------------
module utu8_front import utu8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] code_unit,
	input  logic        string_end,
	input  logic        q_full,
	output logic        push,
	output job_t        job
);

	logic       mode_q;
	logic       held_v_q;
	logic [9:0] held_bits_q;

	logic       accept;
	logic       held_v_d;
	logic [9:0] held_bits_d;
	logic [15:0] u;
	logic       is_high;
	logic       is_low;
	cp_t        held_cp;
	cp_t        pair_cp;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign u       = code_unit[15:0];
	assign is_high = (u[15:10] == SURR_HIGH_TAG);
	assign is_low  = (u[15:10] == SURR_LOW_TAG);
	assign held_cp = {5'd0, SURR_HIGH_TAG, held_bits_q};
	assign pair_cp = SUPP_BASE + {1'b0, held_bits_q, u[9:0]};

	// classify the item
	always_comb begin
		job         = '0;
		held_v_d    = held_v_q;
		held_bits_d = held_bits_q;
		if (mode_q == MODE_UTF32) begin
			held_v_d    = 1'b0;
			held_bits_d = '0;
			if (code_unit <= CP_MAX) begin
				job.first_v  = 1'b1;
				job.first_cp = code_unit[CP_W-1:0];
			end
		end else if (held_v_q && is_low) begin
			held_v_d     = 1'b0;
			held_bits_d  = '0;
			job.first_v  = 1'b1;
			job.first_cp = pair_cp;
		end else begin
			held_v_d    = 1'b0;
			held_bits_d = '0;
			if (held_v_q) begin
				job.first_v  = 1'b1;
				job.first_cp = held_cp;
			end
			if (is_high && !string_end) begin
				held_v_d    = 1'b1;
				held_bits_d = u[9:0];
			end else if (held_v_q) begin
				job.second_v  = 1'b1;
				job.second_cp = {5'd0, u};
			end else begin
				job.first_v  = 1'b1;
				job.first_cp = {5'd0, u};
			end
		end
	end

	assign push = accept && job.first_v;

	// mode register and held surrogate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UTF16;
			held_v_q    <= 1'b0;
			held_bits_q <= '0;
		end else begin
			if (cfg_we) mode_q <= cfg_wdata;
			if (accept) begin
				held_v_q    <= held_v_d;
				held_bits_q <= held_bits_d;
			end
		end
	end

endmodule

>>> rtl/utu8_queue.sv
// ----------------------------------------------------------------------------
// utu8_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module utu8_queue import utu8_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/utu8_back.sv
// ----------------------------------------------------------------------------
// utu8_back
// Pops jobs and emits their UTF-8 bytes, one per cycle while out_stall is low,
// through an output register.
// ----------------------------------------------------------------------------
module utu8_back import utu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] utf8_byte,
	output logic       run_last
);

	logic       busy_q;
	cp_t        cp_q;
	seq_len_t   len_q;
	logic [1:0] idx_q;
	logic       nxt_v_q;
	cp_t        nxt_cp_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic adv;
	logic cp_end;
	logic job_end;

	assign adv     = busy_q && (!out_valid_q || !out_stall);
	assign cp_end  = (idx_q == len_q);
	assign job_end = cp_end && !nxt_v_q;
	assign pop     = !q_empty && (!busy_q || (adv && job_end));

	assign out_valid = out_valid_q;
	assign utf8_byte = byte_q;
	assign run_last  = last_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			nxt_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= 1'b1;
				nxt_v_q <= q_head.second_v;
			end else if (adv && cp_end) begin
				if (nxt_v_q) nxt_v_q <= 1'b0;
				else         busy_q  <= 1'b0;
			end
			if (adv)             out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// code point sequencer and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cp_q     <= q_head.first_cp;
			len_q    <= utf8_len(q_head.first_cp);
			idx_q    <= '0;
			nxt_cp_q <= q_head.second_cp;
		end else if (adv) begin
			if (cp_end) begin
				cp_q  <= nxt_cp_q;
				len_q <= utf8_len(nxt_cp_q);
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (adv) begin
			byte_q <= utf8_byte_at(cp_q, len_q, idx_q);
			last_q <= job_end;
		end
	end

endmodule

>>> rtl/utf16_utf32_to_utf8_transcoder_top.sv
// An accepted item passes through the job queue and the byte sequencer to the
// output register. Throughput: one output byte per cycle while out_stall is
// low; an item that yields bytes yields 1 to 6 (typically 1 to 4), and the
// next job is popped as the last byte of the current one goes out. Items that
// yield nothing are still accepted. Input is taken while the job queue has
// room. Reset (arst_n low) clears mode to UTF-16 and drops any held surrogate and queued jobs.
// ----------------------------------------------------------------------------
// utf16_utf32_to_utf8_transcoder_top
// UTF-16 / UTF-32 code unit to UTF-8 byte stream transcoder.
// ----------------------------------------------------------------------------
module utf16_utf32_to_utf8_transcoder_top import utu8_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] code_unit,
	input  logic        string_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  utf8_byte,
	output logic        run_last
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t q_head;

	utu8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.string_end (string_end),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	utu8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	utu8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.utf8_byte (utf8_byte),
		.run_last  (run_last)
	);

endmodule

>>> tb/sv/utf8_stream_tracker_pkg.sv
// ----------------------------------------------------------------------------
// utf8_stream_tracker_pkg
// Tracks the UTF-8 byte stream the transcoder should produce: predicts the
// bytes for every accepted code unit and checks the bytes that come out.
// ----------------------------------------------------------------------------
package utf8_stream_tracker_pkg;
	import utu8_pkg::*;

	typedef struct {
		logic [7:0] octet;
		logic       run_last;
	} utf8_out_t;

	class utf8_stream_tracker;
		logic       mode;
		logic [9:0] held_bits;
		logic       held;
		utf8_out_t  pending[$];
		utf8_out_t  fresh[$];
		int         errors;
		int         units_seen;
		int         bytes_seen;

		function new();
			mode = MODE_UTF16;
			held_bits = '0;
			held = 1'b0;
			errors = 0;
			units_seen = 0;
			bytes_seen = 0;
		endfunction

		// the register write leaves any held surrogate alone
		function void set_mode(logic m);
			mode = m;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function void stage_octet(logic [7:0] v);
			utf8_out_t t;
			t.octet = v;
			t.run_last = 1'b0;
			fresh.insert(fresh.size(), t);
		endfunction

		// UTF-8 bytes of one code point
		function void stage_cp(cp_t cp);
			if (cp < LIMIT_1B) begin
				stage_octet(8'(cp));
			end else if (cp < LIMIT_2B) begin
				stage_octet(8'hC0 | 8'(cp >> 6));
				stage_octet(8'h80 | 8'(cp & 21'h3F));
			end else if (cp < LIMIT_3B) begin
				stage_octet(8'hE0 | 8'(cp >> 12));
				stage_octet(8'h80 | 8'((cp >> 6) & 21'h3F));
				stage_octet(8'h80 | 8'(cp & 21'h3F));
			end else begin
				stage_octet(8'hF0 | 8'((cp >> 18) & 21'h07));
				stage_octet(8'h80 | 8'((cp >> 12) & 21'h3F));
				stage_octet(8'h80 | 8'((cp >> 6) & 21'h3F));
				stage_octet(8'h80 | 8'(cp & 21'h3F));
			end
		endfunction

		// expected bytes for one accepted unit
		function void note_unit(logic [31:0] unit, logic end_flag);
			logic [15:0] u;
			logic        is_high;
			logic        is_low;
			utf8_out_t   t;
			fresh.delete();
			units_seen++;
			if (mode == MODE_UTF32) begin
				// a held high surrogate is dropped silently
				held = 1'b0;
				held_bits = '0;
				if (unit <= CP_MAX)
					stage_cp(cp_t'(unit));
			end else begin
				u = unit[15:0];
				is_high = (u[15:10] == SURR_HIGH_TAG);
				is_low = (u[15:10] == SURR_LOW_TAG);
				if (held && is_low) begin
					stage_cp(SUPP_BASE + cp_t'({held_bits, u[9:0]}));
					held = 1'b0;
				end else begin
					// unpaired held high goes out on its own
					if (held) begin
						stage_cp(cp_t'({SURR_HIGH_TAG, held_bits}));
						held = 1'b0;
					end
					if (is_high && !end_flag) begin
						held_bits = u[9:0];
						held = 1'b1;
					end else begin
						stage_cp(cp_t'(u));
					end
				end
			end
			if (fresh.size() > 0) begin
				t = fresh[fresh.size()-1];
				t.run_last = 1'b1;
				fresh[fresh.size()-1] = t;
			end
			foreach (fresh[i])
				pending.insert(pending.size(), fresh[i]);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_byte(logic [7:0] octet, logic run_last);
			utf8_out_t want;
			bytes_seen++;
			if (pending.size() == 0) begin
				report($sformatf("byte %02h with nothing expected", octet));
				return;
			end
			want = pending.pop_front();
			if (octet !== want.octet)
				report($sformatf("utf8_byte %02h, expected %02h", octet, want.octet));
			if (run_last !== want.run_last)
				report($sformatf("run_last %b, expected %b (byte %02h)", run_last,
					want.run_last, want.octet));
		endtask
	endclass

endpackage

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives code units into the UTF-16/UTF-32 to UTF-8 transcoder in both modes,
// with random gaps and output stalls, and checks every byte against a
// predicted stream.
// ----------------------------------------------------------------------------
module testbench;
	import utu8_pkg::*;
	import utf8_stream_tracker_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 10;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 14;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] code_unit;
	logic        string_end;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  utf8_byte;
	logic        run_last;

	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;
	int mode_writes = 0;

	utf8_stream_tracker tracker = new();

	utf16_utf32_to_utf8_transcoder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.code_unit (code_unit),
		.string_end(string_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.utf8_byte (utf8_byte),
		.run_last  (run_last)
	);

	always #10 clk = ~clk;

	// monitor: inputs first so a unit is predicted before its bytes show
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_unit(code_unit, string_end);
			if (out_valid && !out_stall)
				tracker.check_byte(utf8_byte, run_last);
		end
	end

	// receiver: random stall before each byte
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = out_idle_en ? $urandom_range(0, 10) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one item, after a random gap; returns at the accepting edge
	task automatic send_unit(input logic [31:0] cu, input logic end_flag);
		int gap;
		gap = in_idle_en ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= cu;
		string_end <= end_flag;
		do @(posedge clk); while (in_stall);
	endtask

	// let everything in flight come out, including units that yield nothing;
	// first waits for the monitor to note the last accepted unit
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_mode(m);
		mode_writes++;
	endtask

	function automatic logic [15:0] rand_bmp();
		return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(16'h0800, 16'hD7FF))
			: 16'($urandom_range(16'hE000, 16'hFFFF));
	endfunction

	function automatic logic rand_end();
		return $urandom_range(0, 7) == 0;
	endfunction

	// UTF-16 traffic: mostly well-formed text, some broken surrogates
	task automatic utf16_burst(input int count);
		int          sent;
		int          kind;
		logic [15:0] upper;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			upper = 16'($urandom());
			if (kind < 20) begin
				send_unit({upper, 16'($urandom_range(0, 16'h7F))}, rand_end());
			end else if (kind < 35) begin
				send_unit({upper, 16'($urandom_range(16'h80, 16'h7FF))}, rand_end());
			end else if (kind < 55) begin
				send_unit({upper, rand_bmp()}, rand_end());
			end else if (kind < 85) begin
				send_unit({upper, 16'($urandom_range(16'hD800, 16'hDBFF))}, 1'b0);
				send_unit({16'($urandom()), 16'($urandom_range(16'hDC00, 16'hDFFF))},
					rand_end());
				sent++;
			end else if (kind < 90) begin
				send_unit({upper, 16'($urandom_range(16'hDC00, 16'hDFFF))}, rand_end());
			end else if (kind < 95) begin
				send_unit({upper, 16'($urandom_range(16'hD800, 16'hDBFF))}, rand_end());
			end else begin
				send_unit($urandom(), rand_end());
			end
			sent++;
		end
	endtask

	// UTF-32 traffic across all sequence lengths and past the top code point
	task automatic utf32_burst(input int count);
		int          kind;
		logic [31:0] v;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 15) v = $urandom_range(0, 32'h7F);
			else if (kind < 30) v = $urandom_range(32'h80, 32'h7FF);
			else if (kind < 55) v = $urandom_range(32'h800, 32'hFFFF);
			else if (kind < 85) v = $urandom_range(32'h10000, 32'h10FFFF);
			else begin
				v = $urandom();
				if (v <= CP_MAX) v = v | 32'hFFE0_0000;
			end
			send_unit(v, rand_end());
		end
	endtask

	// directed corners: sequence-length boundaries and surrogate handling
	task automatic directed_units();
		write_mode(MODE_UTF16);
		send_unit(32'h0000_0000, 1'b0);
		send_unit(32'hFFFF_007F, 1'b0);
		send_unit(32'h0000_0080, 1'b0);
		send_unit(32'h5A5A_07FF, 1'b0);
		send_unit(32'h0000_0800, 1'b0);
		send_unit(32'h0000_FFFF, 1'b1);
		// lowest and highest supplementary pairs
		send_unit(32'h0000_D800, 1'b0);
		send_unit(32'h0000_DC00, 1'b0);
		send_unit(32'hA5A5_DBFF, 1'b0);
		send_unit(32'h0000_DFFF, 1'b1);
		// lone low
		send_unit(32'h0000_DC00, 1'b0);
		// held high broken by a plain character
		send_unit(32'h0000_D812, 1'b0);
		send_unit(32'h0000_0041, 1'b0);
		// held high then a high at string end: six bytes
		send_unit(32'h0000_DBFF, 1'b0);
		send_unit(32'h0000_D800, 1'b1);
		// high surrogate as last unit
		send_unit(32'h0000_D9AB, 1'b1);
		// held high survives a register write
		send_unit(32'h0000_DABC, 1'b0);
		write_mode(MODE_UTF16);
		send_unit(32'h0000_DC01, 1'b0);
		// held high dropped by a UTF-32 unit
		send_unit(32'h0000_D8FF, 1'b0);
		write_mode(MODE_UTF32);
		send_unit(32'h0000_0041, 1'b0);
		send_unit(32'h0010_FFFF, 1'b0);
		send_unit(32'h0011_0000, 1'b0);
		send_unit(32'hFFFF_FFFF, 1'b1);
		send_unit(32'h0000_D800, 1'b0);
		send_unit(32'h0000_DFFF, 1'b1);
		send_unit(32'h0001_0000, 1'b0);
	endtask

	// stimulus
	initial begin
		logic m;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		code_unit <= '0;
		string_end <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_units();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) m = MODE_UTF16;
			else if (p == 1) m = MODE_UTF32;
			else m = logic'($urandom_range(0, 1));
			write_mode(m);
			in_idle_en = ($urandom_range(0, 3) != 0);
			out_idle_en = ($urandom_range(0, 3) != 0);
			if (m == MODE_UTF16) utf16_burst(PHASE_ITEMS);
			else utf32_burst(PHASE_ITEMS);
		end

		drain();
		$display("summary: %0d code units in, %0d UTF-8 bytes checked, %0d mode writes",
			tracker.units_seen, tracker.bytes_seen, mode_writes);
		$display("summary: %0d mismatches", tracker.errors);
		if (tracker.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout: %0d bytes still expected", tracker.outstanding());
		$display("testbench: done, errors");
		$finish;
	end

endmodule
